// ===== rtl/gteha_pkg.sv =====
// ----------------------------------------------------------------------------
// Gaze angles package
// Shared widths, the arctangent table and register indexes for the gaze block.
// ----------------------------------------------------------------------------
`default_nettype none

package gteha_pkg;

  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned TabLen       = 24;
  localparam int unsigned StageIdxW    = 5;
  // Datapath word: coordinates are scaled by 2^(59 - CoordWidth).
  localparam int unsigned DataW   = 64;
  localparam int unsigned AngW    = 32;
  localparam int unsigned ShiftG  = 59 - CoordWidth;
  localparam int unsigned ZShift  = 32 - CoordWidth;
  localparam logic signed [31:0] GainQ27 = 32'sd221024420;
  localparam logic signed [17:0] AngLimit = 18'sd23040;

  localparam logic [2:0] RegEyePitchMax  = 3'd0;
  localparam logic [2:0] RegEyePitchMin  = 3'd1;
  localparam logic [2:0] RegHeadPitchMax = 3'd2;
  localparam logic [2:0] RegHeadPitchMin = 3'd3;
  localparam logic [2:0] RegEyeYawLimit  = 3'd4;
  localparam logic [2:0] RegHeadYawLimit = 3'd5;

  // Partial state passed along the chain of rotation cells.
  typedef struct packed {
    logic                     vld;
    logic                     degen;
    logic signed [DataW-1:0]  x;
    logic signed [DataW-1:0]  y;
    logic signed [AngW-1:0]   ang;
    logic signed [DataW-1:0]  zk;
    logic signed [AngW-1:0]   az;
  } cell_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic signed [AngW-1:0] atan_tab(input logic [StageIdxW-1:0] i);
    logic signed [AngW-1:0] r;
    unique case (i)
      5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967;
      5'd2: r = 32'sd919879;   5'd3: r = 32'sd466945;
      5'd4: r = 32'sd234379;   5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;    5'd7: r = 32'sd29335;
      5'd8: r = 32'sd14668;    5'd9: r = 32'sd7334;
      5'd10: r = 32'sd3667;    5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;     5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;     5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;       5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round 1/65536 degree to 1/256 degree and clamp to the angle range.
  function automatic logic signed [17:0] to_q8(input logic signed [AngW-1:0] a);
    logic signed [AngW:0] t;
    logic signed [AngW-8:0] s;
    logic signed [17:0] v;
    t = (AngW+1)'(a) + (AngW+1)'(128);
    s = $signed(t[AngW:8]);
    if (s > (AngW-7)'(AngLimit)) v = AngLimit;
    else if (s < -(AngW-7)'(AngLimit)) v = -AngLimit;
    else v = s[17:0];
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gaze_target_to_eye_head_angles.sv =====
// ----------------------------------------------------------------------------
// Gaze target to eye and head angles
// One CORDIC cell chain in two halves gives azimuth and elevation, split into eye and head.
// ----------------------------------------------------------------------------
// A new target word is taken every cycle while the output is not held. The result word
// passes through the input register, 16 azimuth cells, 16 elevation cells and the output
// register (the azimuth half hands over to the elevation half by wiring); the chain stalls
// as a whole when the output is held.
`default_nettype none

module gaze_target_to_eye_head_angles (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  signed [gteha_pkg::CoordWidth-1:0] target_x_i,
  input  wire  signed [gteha_pkg::CoordWidth-1:0] target_y_i,
  input  wire  signed [gteha_pkg::CoordWidth-1:0] target_z_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic signed [15:0] head_pitch_o,
  output logic signed [15:0] eye_pitch_o,
  output logic signed [15:0] head_yaw_o,
  output logic signed [15:0] eye_yaw_o,
  output logic        degenerate_o
);
  import gteha_pkg::*;

  localparam int unsigned NCells = 2 * CordicStages;

  logic [6:0] eye_pitch_max_q, head_pitch_max_q, eye_yaw_limit_q, head_yaw_limit_q;
  logic signed [7:0] eye_pitch_min_q, head_pitch_min_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_pitch_max_q  <= 7'd10;
      eye_pitch_min_q  <= -8'sd30;
      head_pitch_max_q <= 7'd20;
      head_pitch_min_q <= -8'sd30;
      eye_yaw_limit_q  <= 7'd40;
      head_yaw_limit_q <= 7'd45;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegEyePitchMax:  eye_pitch_max_q  <= cfg_data_i[6:0];
        RegEyePitchMin:  eye_pitch_min_q  <= cfg_data_i;
        RegHeadPitchMax: head_pitch_max_q <= cfg_data_i[6:0];
        RegHeadPitchMin: head_pitch_min_q <= cfg_data_i;
        RegEyeYawLimit:  eye_yaw_limit_q  <= cfg_data_i[6:0];
        RegHeadYawLimit: head_yaw_limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The whole chain advances when the output register is free.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Input cell: scale coordinates and form z times the gain.
  cell_t in_d, in_q;
  logic signed [DataW-1:0] ax;
  logic signed [DataW-1:0] zprod;
  always_comb begin
    ax    = DataW'(target_x_i);
    if (ax < 0) ax = -ax;
    zprod = DataW'(target_z_i) * DataW'(GainQ27);
    in_d.vld   = in_valid_i;
    in_d.degen = (target_x_i == '0) && (target_y_i == '0);
    in_d.x     = ax <<< ShiftG;
    in_d.y     = DataW'(target_y_i) <<< ShiftG;
    in_d.ang   = '0;
    in_d.zk    = zprod <<< ZShift;
    in_d.az    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_q <= '0;
    else if (adv) in_q <= in_d;
  end

  // Chain of cells; between the two halves the azimuth is parked and z enters.
  cell_t link [NCells+1];
  assign link[0] = in_q;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    cell_t ci;
    if (i == CordicStages) begin : g_hand
      always_comb begin
        ci     = link[i];
        ci.az  = link[i].ang;
        ci.ang = '0;
        ci.y   = link[i].zk;
      end
    end else begin : g_pass
      assign ci = link[i];
    end
    gteha_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .shift_i (StageIdxW'(i % CordicStages)),
      .cell_i  (ci),
      .cell_o  (link[i+1])
    );
  end

  // Final split.
  logic signed [17:0] el, az;
  logic signed [15:0] ep, hp, ey, hy;
  assign el = to_q8(link[NCells].ang);
  assign az = to_q8(link[NCells].az);

  gteha_split u_pitch (
    .ang_i      (el),
    .eye_max_i  ({3'b0, eye_pitch_max_q, 8'd0}),
    .eye_min_i  ({{2{eye_pitch_min_q[7]}}, eye_pitch_min_q, 8'd0}),
    .head_max_i ({3'b0, head_pitch_max_q, 8'd0}),
    .head_min_i ({{2{head_pitch_min_q[7]}}, head_pitch_min_q, 8'd0}),
    .invert_i   (1'b0),
    .eye_o      (ep),
    .head_o     (hp)
  );

  gteha_split u_yaw (
    .ang_i      (az),
    .eye_max_i  ({3'b0, eye_yaw_limit_q, 8'd0}),
    .eye_min_i  (-{3'b0, eye_yaw_limit_q, 8'd0}),
    .head_max_i ({3'b0, head_yaw_limit_q, 8'd0}),
    .head_min_i (-{3'b0, head_yaw_limit_q, 8'd0}),
    .invert_i   (1'b1),
    .eye_o      (ey),
    .head_o     (hy)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= link[NCells].vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      degenerate_o <= link[NCells].degen;
      head_pitch_o <= link[NCells].degen ? '0 : hp;
      eye_pitch_o  <= link[NCells].degen ? '0 : ep;
      head_yaw_o   <= link[NCells].degen ? '0 : hy;
      eye_yaw_o    <= link[NCells].degen ? '0 : ey;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gteha_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One registered vectoring micro-rotation with a fixed shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module gteha_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire [gteha_pkg::StageIdxW-1:0] shift_i,
  input  gteha_pkg::cell_t         cell_i,
  output gteha_pkg::cell_t         cell_o
);
  import gteha_pkg::*;

  cell_t cell_d, cell_q;
  logic signed [DataW-1:0] dx, dy;

  // Rotate toward y = 0 and accumulate the angle.
  always_comb begin
    dx = cell_i.y >>> shift_i;
    dy = cell_i.x >>> shift_i;
    cell_d = cell_i;
    if (!cell_i.y[DataW-1]) begin
      cell_d.x   = cell_i.x + dx;
      cell_d.y   = cell_i.y - dy;
      cell_d.ang = cell_i.ang + atan_tab(shift_i);
    end else begin
      cell_d.x   = cell_i.x - dx;
      cell_d.y   = cell_i.y + dy;
      cell_d.ang = cell_i.ang - atan_tab(shift_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== rtl/gteha_split.sv =====
// ----------------------------------------------------------------------------
// Eye and head split
// Divides one angle between eye and head under their limits.
// ----------------------------------------------------------------------------
`default_nettype none

module gteha_split (
  input  wire signed [17:0] ang_i,
  input  wire signed [17:0] eye_max_i,
  input  wire signed [17:0] eye_min_i,
  input  wire signed [17:0] head_max_i,
  input  wire signed [17:0] head_min_i,
  input  wire               invert_i,
  output logic signed [15:0] eye_o,
  output logic signed [15:0] head_o
);
  import gteha_pkg::*;

  logic signed [18:0] eye, head;

  function automatic logic signed [15:0] sat(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'(AngLimit)) r = 16'(AngLimit);
    else if (v < -19'(AngLimit)) r = -16'(AngLimit);
    else r = v[15:0];
    return r;
  endfunction

  // Eye takes up to its limit; head takes the clamped remainder; eye is negated if invert_i.
  always_comb begin
    eye  = 19'(ang_i);
    head = '0;
    if (ang_i > 18'sd0) begin
      if (ang_i > eye_max_i) begin
        eye  = 19'(eye_max_i);
        head = 19'(ang_i) - 19'(eye_max_i);
        if (head > 19'(head_max_i)) head = 19'(head_max_i);
      end
    end else if (ang_i < eye_min_i) begin
      eye  = 19'(eye_min_i);
      head = 19'(ang_i) - 19'(eye_min_i);
      if (head < 19'(head_min_i)) head = 19'(head_min_i);
    end
    eye_o  = invert_i ? sat(-eye) : sat(eye);
    head_o = sat(head);
  end

endmodule

`default_nettype wire
